/* sv/assert_macros.svh */
// Assertion shorthands used by the RTL of the block allocator.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bab_pkg.sv */
// Shared types and constants of the bitmap arena block allocator.
// Depends on nothing; used by the channel interfaces, the allocator unit and the testbench.
package bab_pkg;

    localparam int ARENA_W  = 3;
    localparam int BLOCK_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 2'd2;

endpackage

/* sv/bab_if.sv */
// Request and response channels of the bitmap arena block allocator.
// Depends on bab_pkg for the field widths.
interface bab_req_if import bab_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ARENA_W-1:0] arena_index;
    logic [BLOCK_W-1:0] block_index;

    modport source (output valid, kind, arena_index, block_index, input ready);
    modport sink   (input valid, kind, arena_index, block_index, output ready);
endinterface

interface bab_rsp_if import bab_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ARENA_W-1:0]  granted_arena;
    logic [BLOCK_W-1:0]  granted_block;
    logic                arena_opened;
    logic                arena_released;

    modport source (output valid, status, granted_arena, granted_block, arena_opened,
                    arena_released, input ready);
    modport sink   (input valid, status, granted_arena, granted_block, arena_opened,
                    arena_released, output ready);
endinterface

/* sv/bab_occ_mem.sv */
// Occupancy bitmap store: one word per arena slot, one read port with a
// registered result and one write port. Depends on nothing else.
module bab_occ_mem #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [WIDTH-1:0] rd_word_reg;
    logic             rd_written_reg;
    logic             rd_first_reg;

    // An entry never written holds its reset value: slot 0 has block 0 taken.
    assign rd_data = rd_written_reg ? rd_word_reg
                   : (rd_first_reg ? WIDTH'(1) : '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg  <= mem[rd_addr];
            rd_first_reg <= (rd_addr == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

endmodule

/* sv/bab_slot_pick.sv */
// Slot selection from the per-slot live and full flags: the first live
// arena with room, and the lowest slot that is free to open. No dependencies.
module bab_slot_pick #(
    parameter int SLOTS  = 8,
    parameter int SLOT_W = 3
) (
    input  logic [SLOTS-1:0]  live,
    input  logic [SLOTS-1:0]  full,
    output logic              fit_found,
    output logic [SLOT_W-1:0] fit_slot,
    output logic              open_found,
    output logic [SLOT_W-1:0] open_slot
);

    // Scanning downward leaves the lowest matching slot in place.
    always_comb
    begin
        fit_found  = 1'b0;
        fit_slot   = '0;
        open_found = 1'b0;
        open_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (live[i] && !full[i])
            begin
                fit_found = 1'b1;
                fit_slot  = SLOT_W'(i);
            end
            if (!live[i])
            begin
                open_found = 1'b1;
                open_slot  = SLOT_W'(i);
            end
        end
    end

endmodule

/* sv/bitmap_arena_block_allocator_unit.sv */
// Fixed-size block allocator over ARENA_SLOTS arenas of BLOCKS_IN_ARENA blocks.
// An allocate takes the lowest free block of the lowest live arena that has
// room, or opens the lowest free slot and grants its block 0; a free clears
// one block and releases the arena once it is empty. Every request word gives
// exactly one response word. Each request reads the arena's bitmap from the
// occupancy memory as it is taken, then modifies it and writes it back, and a
// new request waits until the last one is finished. Live and full flags sit in
// flip-flops, so the arena search needs no memory reads. The response sits in
// an output register; while it is not taken, a second request is accepted but
// finishes only once the register frees up. No clearing pass follows reset.
// Depends on bab_pkg, bab_if, bab_occ_mem, bab_slot_pick and assert_macros.svh.
`include "assert_macros.svh"

module bitmap_arena_block_allocator_unit import bab_pkg::*; #(
    parameter int BLOCKS_IN_ARENA = 64,
    parameter int ARENA_SLOTS     = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    bab_req_if.sink   req,
    bab_rsp_if.source rsp
);

    localparam int SLOT_W = (ARENA_SLOTS > 1) ? $clog2(ARENA_SLOTS) : 1;
    localparam int BIDX_W = (BLOCKS_IN_ARENA > 1) ? $clog2(BLOCKS_IN_ARENA) : 1;
    localparam logic [BLOCKS_IN_ARENA-1:0] FULL_MAP  = {BLOCKS_IN_ARENA{1'b1}};
    localparam logic [BLOCKS_IN_ARENA-1:0] FIRST_MAP = BLOCKS_IN_ARENA'(1);

    typedef enum logic {S_IDLE, S_MODIFY} state_t;

    state_t                     state_reg, state_next;
    logic                       kind_reg, kind_next;
    logic                       hit_reg, hit_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [BIDX_W-1:0]          block_reg, block_next;
    logic [ARENA_SLOTS-1:0]     live_reg, live_next;
    logic [ARENA_SLOTS-1:0]     full_reg, full_next;

    logic                       rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic [ARENA_W-1:0]         garena_reg, garena_next;
    logic [BLOCK_W-1:0]         gblock_reg, gblock_next;
    logic                       opened_reg, opened_next;
    logic                       released_reg, released_next;

    logic                       pick_fit_found;
    logic [SLOT_W-1:0]          pick_fit_slot;
    logic                       pick_open_found;
    logic [SLOT_W-1:0]          pick_open_slot;

    logic                       mem_rd_en;
    logic [SLOT_W-1:0]          mem_rd_addr;
    logic [BLOCKS_IN_ARENA-1:0] mem_rd_data;
    logic                       mem_wr_en;
    logic [SLOT_W-1:0]          mem_wr_addr;
    logic [BLOCKS_IN_ARENA-1:0] mem_wr_data;

    logic                       accept;
    logic                       out_load;
    logic                       arena_ok;
    logic                       block_ok;
    logic [BIDX_W-1:0]          zero_idx;
    logic [BLOCKS_IN_ARENA-1:0] set_map;
    logic [BLOCKS_IN_ARENA-1:0] clr_map;

    bab_slot_pick #(
        .SLOTS  (ARENA_SLOTS),
        .SLOT_W (SLOT_W)
    ) u_slot_pick (
        .live       (live_reg),
        .full       (full_reg),
        .fit_found  (pick_fit_found),
        .fit_slot   (pick_fit_slot),
        .open_found (pick_open_found),
        .open_slot  (pick_open_slot)
    );

    bab_occ_mem #(
        .DEPTH  (ARENA_SLOTS),
        .WIDTH  (BLOCKS_IN_ARENA),
        .ADDR_W (SLOT_W)
    ) u_occ_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign req.ready          = (state_reg == S_IDLE);
    assign accept             = req.valid && (state_reg == S_IDLE);
    assign out_load           = !rsp_valid_reg || rsp.ready;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.granted_arena  = garena_reg;
    assign rsp.granted_block  = gblock_reg;
    assign rsp.arena_opened   = opened_reg;
    assign rsp.arena_released = released_reg;

    assign arena_ok = (32'(req.arena_index) < ARENA_SLOTS);
    assign block_ok = (32'(req.block_index) < BLOCKS_IN_ARENA);

    // The bitmap is read as the request is taken; the write-back of the
    // previous word has always landed by then, so no forwarding is needed.
    assign mem_rd_en   = accept;
    assign mem_rd_addr = (req.kind == KIND_ALLOC) ? pick_fit_slot : SLOT_W'(req.arena_index);

    always_comb
    begin
        zero_idx = '0;
        for (int i = BLOCKS_IN_ARENA - 1; i >= 0; i--)
        begin
            if (!mem_rd_data[i])
            begin
                zero_idx = BIDX_W'(i);
            end
        end
    end

    assign set_map = mem_rd_data | (FIRST_MAP << zero_idx);
    assign clr_map = mem_rd_data & ~(FIRST_MAP << block_reg);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        block_next     = block_reg;
        live_next      = live_reg;
        full_next      = full_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        garena_next    = garena_reg;
        gblock_next    = gblock_reg;
        opened_next    = opened_reg;
        released_next  = released_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = slot_reg;
        mem_wr_data    = mem_rd_data;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    block_next = BIDX_W'(req.block_index);
                    if (req.kind == KIND_ALLOC)
                    begin
                        slot_next = pick_fit_slot;
                        hit_next  = pick_fit_found;
                    end
                    else
                    begin
                        slot_next = SLOT_W'(req.arena_index);
                        hit_next  = arena_ok && block_ok;
                    end
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                if (out_load)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    garena_next    = '0;
                    gblock_next    = '0;
                    opened_next    = 1'b0;
                    released_next  = 1'b0;
                    if (kind_reg == KIND_ALLOC)
                    begin
                        if (hit_reg)
                        begin
                            mem_wr_en           = 1'b1;
                            mem_wr_data         = set_map;
                            full_next[slot_reg] = (set_map == FULL_MAP);
                            garena_next         = ARENA_W'(slot_reg);
                            gblock_next         = BLOCK_W'(zero_idx);
                        end
                        else if (pick_open_found)
                        begin
                            mem_wr_en                 = 1'b1;
                            mem_wr_addr               = pick_open_slot;
                            mem_wr_data               = FIRST_MAP;
                            live_next[pick_open_slot] = 1'b1;
                            full_next[pick_open_slot] = (FIRST_MAP == FULL_MAP);
                            garena_next               = ARENA_W'(pick_open_slot);
                            opened_next               = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_NO_SLOT;
                        end
                    end
                    else
                    begin
                        if (hit_reg && mem_rd_data[block_reg])
                        begin
                            mem_wr_en           = 1'b1;
                            mem_wr_data         = clr_map;
                            full_next[slot_reg] = 1'b0;
                            if (clr_map == '0)
                            begin
                                live_next[slot_reg] = 1'b0;
                                released_next       = 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = ST_DOUBLE_FREE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= ARENA_SLOTS'(1);
            full_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            full_reg      <= full_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        block_reg    <= block_next;
        status_reg   <= status_next;
        garena_reg   <= garena_next;
        gblock_reg   <= gblock_next;
        opened_reg   <= opened_next;
        released_reg <= released_next;
    end

    // A full arena is always a live one.
    `ASSERT_ALWAYS(a_full_is_live, clk, rst_n, ((full_reg & ~live_reg) == '0), "full arena not live")

    // Opening an arena adds exactly one live slot.
    `ASSERT_NEXT(a_open_adds_live, clk, rst_n, (state_reg == S_MODIFY && out_load && kind_reg == KIND_ALLOC && !hit_reg && pick_open_found), ($countones(live_reg) == $countones($past(live_reg)) + 1), "arena open did not add a live slot")

    // A released arena comes only from a good free, never with an open.
    `ASSERT_SAME(a_release_ok, clk, rst_n, (rsp_valid_reg && released_reg), (status_reg == ST_OK && !opened_reg), "release word with bad status")

endmodule

/* tb/bab_alloc_checker.sv */
`timescale 1ns / 1ps
// Response checker for the bitmap arena block allocator: keeps its own arena bitmaps,
// predicts one response word per accepted request word and compares them in order.
// Depends on bab_pkg and the bab_req_if / bab_rsp_if channel interfaces.
module bab_alloc_checker import bab_pkg::*; #(
    parameter int BLOCKS_IN_ARENA = 64,
    parameter int ARENA_SLOTS     = 8
) (
    input  logic clk,
    input  logic rst_n,
    bab_req_if   req,
    bab_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ARENA_W-1:0]  arena;
        logic [BLOCK_W-1:0]  blk;
        logic                opened;
        logic                released;
    } grant_word_t;

    localparam logic [63:0] FULL_MAP =
        (BLOCKS_IN_ARENA >= 64) ? {64{1'b1}} : ((64'd1 << BLOCKS_IN_ARENA) - 64'd1);

    logic [63:0]            occ_map [ARENA_SLOTS];
    logic [ARENA_SLOTS-1:0] arena_live;
    grant_word_t            expected_grants[$];

    // Applies one request to the bitmaps and returns the response word it gives.
    function automatic grant_word_t apply_request(input logic kind,
                                                  input logic [ARENA_W-1:0] ai,
                                                  input logic [BLOCK_W-1:0] bi);
        grant_word_t r;
        logic        found;
        r     = '0;
        found = 1'b0;
        if (kind == KIND_ALLOC)
        begin
            for (int s = 0; s < ARENA_SLOTS; s++)
            begin
                if (!found && arena_live[s] && occ_map[s] != FULL_MAP)
                begin
                    for (int b = 0; b < BLOCKS_IN_ARENA && b < 64; b++)
                    begin
                        if (!found && !occ_map[s][b])
                        begin
                            occ_map[s][b] = 1'b1;
                            r.arena       = ARENA_W'(s);
                            r.blk         = BLOCK_W'(b);
                            found         = 1'b1;
                        end
                    end
                end
            end
            // Every live arena is full: open the lowest slot that is not live.
            for (int s = 0; s < ARENA_SLOTS; s++)
            begin
                if (!found && !arena_live[s])
                begin
                    arena_live[s] = 1'b1;
                    occ_map[s]    = 64'd1;
                    r.arena       = ARENA_W'(s);
                    r.blk         = '0;
                    r.opened      = 1'b1;
                    found         = 1'b1;
                end
            end
            if (!found)
                r.status = ST_NO_SLOT;
        end
        else
        begin
            if (int'(ai) < ARENA_SLOTS && occ_map[ai][bi])
            begin
                occ_map[ai][bi] = 1'b0;
                if (occ_map[ai] == 64'd0)
                begin
                    arena_live[ai] = 1'b0;
                    r.released     = 1'b1;
                end
            end
            else
            begin
                r.status = ST_DOUBLE_FREE;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_word_t exp_w;
        grant_word_t act_w;
        if (!rst_n)
        begin
            for (int s = 0; s < ARENA_SLOTS; s++)
                occ_map[s] = '0;
            occ_map[0] = 64'd1;
            arena_live = ARENA_SLOTS'(1);
            expected_grants.delete();
            fail_count = 0;
        end
        else
        begin
            // The response is checked before the new request is queued, since a word
            // answered at this edge always belongs to an earlier request.
            if (rsp.valid && rsp.ready)
            begin
                act_w = {rsp.status, rsp.granted_arena, rsp.granted_block,
                         rsp.arena_opened, rsp.arena_released};
                if (expected_grants.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: response word with none expected: st=%0d a=%0d b=%0d op=%0d rel=%0d",
                                 $realtime, act_w.status, act_w.arena, act_w.blk,
                                 act_w.opened, act_w.released);
                end
                else
                begin
                    exp_w = expected_grants.pop_front();
                    if (act_w != exp_w)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: exp st=%0d a=%0d b=%0d op=%0d rel=%0d, ",
                                      "got st=%0d a=%0d b=%0d op=%0d rel=%0d"},
                                     $realtime, exp_w.status, exp_w.arena, exp_w.blk,
                                     exp_w.opened, exp_w.released, act_w.status,
                                     act_w.arena, act_w.blk, act_w.opened, act_w.released);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_grants.push_back(apply_request(req.kind, req.arena_index,
                                                        req.block_index));
        end
        pending = expected_grants.size();
    end

endmodule

/* tb/bitmap_arena_block_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the block allocator testbench: clock, reset, request stimulus and response
// stalls, with bab_alloc_checker doing the prediction. Depends on bab_pkg, bab_if,
// bitmap_arena_block_allocator_unit and bab_alloc_checker.
module bitmap_arena_block_allocator_unit_tb;
    import bab_pkg::*;

    typedef struct packed {
        logic [ARENA_W-1:0] arena;
        logic [BLOCK_W-1:0] blk;
    } block_ref_t;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_LONG_STALL} ready_style_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    block_ref_t   held_blocks[$];
    logic         sent_kinds[$];
    ready_style_t ready_mode;
    int           ready_seg_left;
    int           stall_left;

    bab_req_if req_ch ();
    bab_rsp_if rsp_ch ();

    bitmap_arena_block_allocator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bab_alloc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // Keeps the blocks granted so far, so that most frees name a block really held.
    always @(posedge clk)
    begin
        logic k;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready && sent_kinds.size() > 0)
            begin
                k = sent_kinds.pop_front();
                if (k == KIND_ALLOC && rsp_ch.status == ST_OK)
                    held_blocks.push_back({rsp_ch.granted_arena, rsp_ch.granted_block});
            end
            if (req_ch.valid && req_ch.ready)
                sent_kinds.push_back(req_ch.kind);
        end
    end

    // Response stalls: segments of always ready, coin flips, or long stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready = 1'b0;
        end
        else
        begin
            if (ready_seg_left == 0)
            begin
                ready_mode     = ready_style_t'($urandom_range(0, 2));
                ready_seg_left = $urandom_range(20, 80);
            end
            ready_seg_left--;
            case (ready_mode)
                RDY_ALWAYS: rsp_ch.ready = 1'b1;
                RDY_COIN:   rsp_ch.ready = 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_left > 0)
                    begin
                        rsp_ch.ready = 1'b0;
                        stall_left--;
                    end
                    else
                    begin
                        rsp_ch.ready = 1'b1;
                        stall_left   = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic k, input logic [ARENA_W-1:0] a,
                             input logic [BLOCK_W-1:0] b);
        req_ch.valid       = 1'b1;
        req_ch.kind        = k;
        req_ch.arena_index = a;
        req_ch.block_index = b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int alloc_pct, input int noise_pct);
        int         sent;
        int         burst;
        int         gap;
        int         roll;
        int         idx;
        block_ref_t victim;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < count)
            begin
                roll = $urandom_range(0, 99);
                if (roll < noise_pct)
                begin
                    send_word(KIND_FREE, ARENA_W'($urandom_range(0, 7)),
                              BLOCK_W'($urandom_range(0, 63)));
                end
                else if (roll < noise_pct + alloc_pct || held_blocks.size() == 0)
                begin
                    send_word(KIND_ALLOC, ARENA_W'($urandom_range(0, 7)),
                              BLOCK_W'($urandom_range(0, 63)));
                end
                else
                begin
                    // Mostly the newest grant, so whole arenas empty out and get released.
                    if ($urandom_range(0, 9) < 7)
                        idx = held_blocks.size() - 1;
                    else
                        idx = $urandom_range(0, held_blocks.size() - 1);
                    victim = held_blocks[idx];
                    held_blocks.delete(idx);
                    send_word(KIND_FREE, victim.arena, victim.blk);
                end
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_ALLOC;
        req_ch.arena_index = '0;
        req_ch.block_index = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Freeing the only block releases arena 0, so no arena is live afterwards.
        send_word(KIND_FREE, 3'd0, 6'd0);
        send_word(KIND_FREE, 3'd0, 6'd0);
        send_word(KIND_ALLOC, 3'd0, 6'd0);
        send_word(KIND_ALLOC, 3'd7, 6'd63);
        send_word(KIND_ALLOC, 3'd5, 6'd42);
        send_word(KIND_ALLOC, 3'd2, 6'd21);
        send_word(KIND_FREE, 3'd7, 6'd63);
        send_word(KIND_FREE, 3'd0, 6'd63);
        send_word(KIND_FREE, 3'd0, 6'd2);
        send_word(KIND_ALLOC, 3'd0, 6'd0);
        send_word(KIND_FREE, 3'd0, 6'd3);
        send_word(KIND_FREE, 3'd0, 6'd3);
        send_word(KIND_ALLOC, 3'd7, 6'd63);
        send_word(KIND_FREE, 3'd1, 6'd0);
        req_ch.valid = 1'b0;
        @(negedge clk);

        // Fill every arena and run past the last slot.
        run_phase(560, 97, 3);

        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);

        // Drain, releasing arenas, then a balanced mix.
        run_phase(420, 12, 5);
        run_phase(150, 50, 10);

        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/bab_pkg.sv
sv/bab_if.sv
sv/bab_occ_mem.sv
sv/bab_slot_pick.sv
sv/bitmap_arena_block_allocator_unit.sv
tb/bab_alloc_checker.sv
tb/bitmap_arena_block_allocator_unit_tb.sv
